FILE: hw/rtl/pktl_pkg.sv
// Shared types, codes and the port check for the partition key table lookup.
package pktl_pkg;

  localparam int PORTS_DEF       = 2;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [15:0] KEY_LOW_MASK = 16'h7fff;
  localparam logic [15:0] KEY_FULL_BIT = 16'h8000;
  localparam logic [15:0] KEY_NONE     = 16'h0000;
  localparam logic [15:0] NO_INDEX     = 16'hffff;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_COMMIT = 3'd2,
    CMD_GET    = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_EXACT  = 3'd5,
    CMD_LMC    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    REG_IS_SWITCH  = 1'b0,
    REG_PORT_COUNT = 1'b1
  } reg_t;

  typedef enum logic [1:0] {
    OP_COMMIT,
    OP_GET,
    OP_FIND,
    OP_EXACT
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [15:0] key;
    logic [15:0] tidx;
    logic        found;
    logic [15:0] hit;
    logic        partial;
    logic [15:0] pidx;
  } token_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] slot;
  } port_chk_t;

  function automatic port_chk_t port_check(logic [7:0] port, logic is_sw,
                                           logic [1:0] pcnt, int ports);
    port_chk_t  r;
    logic [7:0] first;
    logic [7:0] last;
    logic [7:0] ofs;
    first  = is_sw ? 8'd0 : 8'd1;
    last   = is_sw ? 8'd0 : {6'd0, pcnt};
    ofs    = port - first;
    r.ok   = (port >= first) && (port <= last) && (int'(ofs) < ports);
    r.slot = ofs;
    return r;
  endfunction

endpackage

FILE: hw/rtl/pktl_cell.sv
// One table cell: staged entry, committed entry per port, and one search step.
module pktl_cell #(
  parameter int PORTS  = pktl_pkg::PORTS_DEF,
  parameter int SLOT_W = 1,
  parameter int CNT_W  = 7,
  parameter int IDX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                st_we,
  input  logic [CNT_W-1:0]    st_count,
  input  logic [31:0]         st_data,
  input  pktl_pkg::token_t    tok_in,
  input  logic [SLOT_W-1:0]   slot_in,
  input  logic [CNT_W-1:0]    cnt_in,
  output pktl_pkg::token_t    tok_out,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [CNT_W-1:0]    cnt_out
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [31:0]      staged;
  logic [31:0]      entries [PORTS];
  logic [31:0]      entry;
  logic             active;
  pktl_pkg::token_t tok_next;

  assign entry  = entries[slot_in];
  assign active = tok_in.valid && (cnt_in > IDX_C);

  always_comb begin
    tok_next = tok_in;
    if (active && !tok_in.found) begin
      unique case (tok_in.op)
        pktl_pkg::OP_COMMIT: ;
        pktl_pkg::OP_GET: begin
          if (entry[31:16] == tok_in.tidx) begin
            tok_next.found = 1'b1;
            tok_next.hit   = entry[15:0];
          end
        end
        pktl_pkg::OP_FIND: begin
          if ((entry[15:0] & pktl_pkg::KEY_LOW_MASK) ==
              (tok_in.key & pktl_pkg::KEY_LOW_MASK)) begin
            if ((entry[15:0] & pktl_pkg::KEY_FULL_BIT) != pktl_pkg::KEY_NONE) begin
              tok_next.found = 1'b1;
              tok_next.hit   = entry[31:16];
            end else begin
              tok_next.partial = 1'b1;
              tok_next.pidx    = entry[31:16];
            end
          end
        end
        pktl_pkg::OP_EXACT: begin
          if (entry[15:0] == tok_in.key) begin
            tok_next.found = 1'b1;
            tok_next.hit   = entry[31:16];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_we && (st_count == IDX_C)) begin
      staged <= st_data;
    end
    if (active && (tok_in.op == pktl_pkg::OP_COMMIT)) begin
      entries[slot_in] <= staged;
    end
    slot_out <= slot_in;
    cnt_out  <= cnt_in;
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: hw/rtl/partition_key_table_lookup.sv
// Top level: command decode, port state and the row of table cells.
//
// Partition key table with staged update. A command transfer happens when start
// is high and busy is low. Begin update, load entry, get LMC, and any command
// rejected up front return their result in the cycle after the transfer. Commit,
// get by index and both find commands send a token down the row of
// TABLE_DEPTH cells, one cell per cycle, and return their result through
// a register behind the last cell; busy is high meanwhile. Each
// result is shown for exactly one cycle with done high and cannot be held
// off, so the receiver must take it in that cycle. Configuration writes
// apply at once and must only be issued while no command is in progress.
module partition_key_table_lookup #(
  parameter int PORTS       = pktl_pkg::PORTS_DEF,
  parameter int TABLE_DEPTH = pktl_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [7:0]  port,
  input  logic [15:0] table_index,
  input  logic [15:0] key_in,
  input  logic [2:0]  lmc_in,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] key_out,
  output logic [15:0] index_out,
  output logic [2:0]  lmc_out
);

  localparam int SLOT_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  pktl_pkg::state_t  state, state_next;

  logic              is_switch;
  logic [1:0]        port_count;
  logic [CNT_W-1:0]  entry_counts [PORTS];
  logic [2:0]        port_lmc [PORTS];
  logic [CNT_W-1:0]  staged_count;
  logic [7:0]        staged_port;

  pktl_pkg::token_t  tok  [TABLE_DEPTH+1];
  logic [SLOT_W-1:0] slot [TABLE_DEPTH+1];
  logic [CNT_W-1:0]  cnt  [TABLE_DEPTH+1];

  pktl_pkg::port_chk_t chk_port, chk_stage;
  logic              accept;
  logic              sel_ok;
  logic [SLOT_W-1:0] sel_slot;
  logic [CNT_W-1:0]  sel_cnt;
  logic              inject;
  logic              st_we;
  logic              begin_ok;
  logic              commit_ok;
  logic              res_load;
  pktl_pkg::status_t imm_status;
  logic [2:0]        imm_lmc;
  pktl_pkg::status_t fin_status;
  logic [15:0]       fin_key;
  logic [15:0]       fin_idx;
  pktl_pkg::op_t     inj_op;

  assign busy   = (state == pktl_pkg::S_SCAN);
  assign accept = start && !busy;

  assign chk_port  = pktl_pkg::port_check(port, is_switch, port_count, PORTS);
  assign chk_stage = pktl_pkg::port_check(staged_port, is_switch, port_count, PORTS);
  assign sel_ok    = (pktl_pkg::cmd_t'(cmd) == pktl_pkg::CMD_COMMIT) ? chk_stage.ok
                                                                     : chk_port.ok;
  assign sel_slot  = (pktl_pkg::cmd_t'(cmd) == pktl_pkg::CMD_COMMIT) ?
                     SLOT_W'(chk_stage.slot) : SLOT_W'(chk_port.slot);
  assign sel_cnt   = entry_counts[sel_slot];

  // Decode the command at transfer
  always_comb begin
    inject     = 1'b0;
    inj_op     = pktl_pkg::OP_COMMIT;
    st_we      = 1'b0;
    begin_ok   = 1'b0;
    commit_ok  = 1'b0;
    res_load   = 1'b0;
    imm_status = pktl_pkg::STAT_OK;
    imm_lmc    = 3'd0;
    if (accept) begin
      unique case (pktl_pkg::cmd_t'(cmd))
        pktl_pkg::CMD_BEGIN: begin
          res_load = 1'b1;
          if (sel_ok) begin
            begin_ok = 1'b1;
          end else begin
            imm_status = pktl_pkg::STAT_INVALID;
          end
        end
        pktl_pkg::CMD_LOAD: begin
          res_load = 1'b1;
          if (key_in != pktl_pkg::KEY_NONE) begin
            if (staged_count >= DEPTH_C) begin
              imm_status = pktl_pkg::STAT_FULL;
            end else begin
              st_we = 1'b1;
            end
          end
        end
        pktl_pkg::CMD_COMMIT: begin
          if (sel_ok) begin
            commit_ok = 1'b1;
            inject    = 1'b1;
            inj_op    = pktl_pkg::OP_COMMIT;
          end else begin
            res_load   = 1'b1;
            imm_status = pktl_pkg::STAT_INVALID;
          end
        end
        pktl_pkg::CMD_GET: begin
          if (sel_ok && (table_index < 16'(sel_cnt))) begin
            inject = 1'b1;
            inj_op = pktl_pkg::OP_GET;
          end else begin
            res_load   = 1'b1;
            imm_status = pktl_pkg::STAT_INVALID;
          end
        end
        pktl_pkg::CMD_FIND, pktl_pkg::CMD_EXACT: begin
          if (sel_ok) begin
            inject = 1'b1;
            inj_op = (pktl_pkg::cmd_t'(cmd) == pktl_pkg::CMD_FIND) ? pktl_pkg::OP_FIND
                                                                   : pktl_pkg::OP_EXACT;
          end else begin
            res_load   = 1'b1;
            imm_status = pktl_pkg::STAT_INVALID;
          end
        end
        pktl_pkg::CMD_LMC: begin
          res_load = 1'b1;
          if (sel_ok) begin
            imm_lmc = port_lmc[sel_slot];
          end else begin
            imm_status = pktl_pkg::STAT_INVALID;
          end
        end
        default: begin
          res_load   = 1'b1;
          imm_status = pktl_pkg::STAT_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pktl_pkg::S_IDLE: begin
        if (inject) begin
          state_next = pktl_pkg::S_SCAN;
        end
      end
      pktl_pkg::S_SCAN: begin
        if (tok[TABLE_DEPTH].valid) begin
          state_next = pktl_pkg::S_IDLE;
        end
      end
      default: state_next = pktl_pkg::S_IDLE;
    endcase
  end

  // Head of the row
  always_comb begin
    tok[0].valid   = inject;
    tok[0].op      = inj_op;
    tok[0].key     = key_in;
    tok[0].tidx    = table_index;
    tok[0].found   = 1'b0;
    tok[0].hit     = pktl_pkg::KEY_NONE;
    tok[0].partial = 1'b0;
    tok[0].pidx    = pktl_pkg::NO_INDEX;
    slot[0]        = sel_slot;
    cnt[0]         = commit_ok ? staged_count : sel_cnt;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pktl_cell #(
      .PORTS  (PORTS),
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .IDX    (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .st_we    (st_we),
      .st_count (staged_count),
      .st_data  ({table_index, key_in}),
      .tok_in   (tok[i]),
      .slot_in  (slot[i]),
      .cnt_in   (cnt[i]),
      .tok_out  (tok[i+1]),
      .slot_out (slot[i+1]),
      .cnt_out  (cnt[i+1])
    );
  end

  // Tail of the row
  always_comb begin
    fin_status = pktl_pkg::STAT_OK;
    fin_key    = pktl_pkg::KEY_NONE;
    fin_idx    = pktl_pkg::NO_INDEX;
    unique case (tok[TABLE_DEPTH].op)
      pktl_pkg::OP_COMMIT: ;
      pktl_pkg::OP_GET: begin
        if (tok[TABLE_DEPTH].found) begin
          fin_key = tok[TABLE_DEPTH].hit;
        end
      end
      pktl_pkg::OP_FIND: begin
        if (tok[TABLE_DEPTH].found) begin
          fin_idx = tok[TABLE_DEPTH].hit;
        end else if (tok[TABLE_DEPTH].partial) begin
          fin_idx = tok[TABLE_DEPTH].pidx;
        end else begin
          fin_status = pktl_pkg::STAT_NOT_FOUND;
        end
      end
      pktl_pkg::OP_EXACT: begin
        if (tok[TABLE_DEPTH].found) begin
          fin_idx = tok[TABLE_DEPTH].hit;
        end else begin
          fin_status = pktl_pkg::STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pktl_pkg::S_IDLE;
      is_switch    <= 1'b0;
      port_count   <= 2'd1;
      staged_count <= '0;
      staged_port  <= 8'd0;
      done         <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        entry_counts[p] <= '0;
        port_lmc[p]     <= 3'd0;
      end
    end else begin
      state <= state_next;
      done  <= res_load || tok[TABLE_DEPTH].valid;
      if (cfg_we) begin
        unique case (pktl_pkg::reg_t'(cfg_index))
          pktl_pkg::REG_IS_SWITCH:  is_switch  <= cfg_data[0];
          pktl_pkg::REG_PORT_COUNT: port_count <= cfg_data;
          default: ;
        endcase
      end
      if (begin_ok) begin
        staged_port  <= port;
        staged_count <= '0;
      end
      if (st_we) begin
        staged_count <= staged_count + 1'b1;
      end
      if (commit_ok) begin
        entry_counts[sel_slot] <= staged_count;
        port_lmc[sel_slot]     <= lmc_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status    <= imm_status;
      key_out   <= pktl_pkg::KEY_NONE;
      index_out <= pktl_pkg::NO_INDEX;
      lmc_out   <= imm_lmc;
    end else if (tok[TABLE_DEPTH].valid) begin
      status    <= fin_status;
      key_out   <= fin_key;
      index_out <= fin_idx;
      lmc_out   <= 3'd0;
    end
  end

endmodule
